// ===== rtl/fpfl_pkg.sv =====
package fpfl_pkg;

    // Request codes carried in the op field.
    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    // Result status codes.
    localparam logic STS_DONE      = 1'b0;
    localparam logic STS_EXHAUSTED = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic alloc;
        logic release_req;
        logic fetch;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic head_end;
    } t_dp_sts;

endpackage

// ===== rtl/fpfl_ctrl.sv =====
module fpfl_ctrl
    import fpfl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        accept     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // The result register frees up when its content is taken this cycle.
                o_in_ready = !r_out_valid || i_out_ready;
                accept     = o_in_ready && i_in_valid;
                if (accept) begin
                    o_cmd.load_out = 1'b1;
                    if (i_op == OP_ALLOCATE) begin
                        o_cmd.alloc = 1'b1;
                        if (!i_sts.head_end) begin
                            n_state = ST_FETCH;
                        end
                    end else begin
                        o_cmd.release_req = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        n_out_valid = o_cmd.load_out ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/fpfl_dp.sv =====
module fpfl_dp
    import fpfl_pkg::*;
#(
    parameter int SLOTS  = 64,
    parameter int SLOT_W = $clog2(SLOTS),
    parameter int CNT_W  = $clog2(SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [SLOT_W-1:0] i_release_slot,
    output t_dp_sts           o_sts,
    output logic              o_status,
    output logic [SLOT_W-1:0] o_granted_slot,
    output logic [CNT_W-1:0]  o_free_count
);

    localparam logic [CNT_W-1:0] END_MARK = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Link memory: each entry names the next free slot or holds the end mark.
    logic [CNT_W-1:0]  r_link_mem [SLOTS];
    logic [SLOT_W-1:0] r_clr_idx;
    logic [CNT_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_head_link;
    logic [CNT_W-1:0]  r_free;
    logic [CNT_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_head_link;
    logic [CNT_W-1:0]  n_free;
    logic              r_status;
    logic [SLOT_W-1:0] r_granted;
    logic [CNT_W-1:0]  r_out_free;
    logic              head_end;
    logic              rel_ok;

    assign head_end = (r_head >= END_MARK);
    assign rel_ok   = (CNT_W'(i_release_slot) < END_MARK);

    always_comb begin
        n_head      = r_head;
        n_head_link = r_head_link;
        n_free      = r_free;
        if (i_cmd.alloc && !head_end) begin
            n_head = r_head_link;
            n_free = (r_free != '0) ? r_free - CNT_W'(1) : '0;
        end else if (i_cmd.release_req && rel_ok) begin
            n_head      = CNT_W'(i_release_slot);
            n_head_link = r_head;
            n_free      = (r_free < END_MARK) ? r_free + CNT_W'(1) : END_MARK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_link_mem[r_clr_idx] <= CNT_W'(r_clr_idx) + CNT_W'(1);
        end else if (i_cmd.release_req && rel_ok) begin
            r_link_mem[i_release_slot] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_head      <= '0;
            r_head_link <= CNT_W'(1);
            r_free      <= END_MARK;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + SLOT_W'(1);
            end
            r_head <= n_head;
            r_free <= n_free;
            if (i_cmd.fetch) begin
                if (!head_end) begin
                    r_head_link <= r_link_mem[r_head[SLOT_W-1:0]];
                end
            end else begin
                r_head_link <= n_head_link;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status   <= (i_cmd.alloc && head_end) ? STS_EXHAUSTED : STS_DONE;
            r_granted  <= (i_cmd.alloc && !head_end) ? r_head[SLOT_W-1:0] : '0;
            r_out_free <= n_free;
        end
    end

    assign o_sts.clr_last = (r_clr_idx == LAST_SLOT);
    assign o_sts.head_end = head_end;
    assign o_status       = r_status;
    assign o_granted_slot = r_granted;
    assign o_free_count   = r_out_free;

endmodule

// ===== rtl/fixed_pool_free_list_allocator.sv =====
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  op, release_slot
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  status, granted_slot, free_count
//
// A release completes when it is accepted; an allocate that grants a slot then passes
// through a fetch state that reads the new head's link from the link memory into the prefetch register.
// An exhausted allocate completes when it is accepted, with no fetch state.
// After reset a clearing pass writes all SLOTS link entries to load the link chain; no transaction is
// accepted during it.
// A result waits in the output register; the next request is still accepted while the
// register is full, provided the waiting result is taken in that same cycle.
module fixed_pool_free_list_allocator
    import fpfl_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // Fields from bit 0 up: op, release_slot, zero padding.
    input  logic [((1 + $clog2(SLOTS) + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // Fields from bit 0 up: status, granted_slot, free_count, zero padding.
    output logic [((1 + $clog2(SLOTS) + $clog2(SLOTS + 1) + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int OUT_W   = 1 + SLOT_W + CNT_W;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8 - OUT_W;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              out_status;
    logic [SLOT_W-1:0] out_granted;
    logic [CNT_W-1:0]  out_free;

    // The controller sequences the clearing pass, request acceptance and link fetch.
    fpfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_op        (i_s_axis_tdata[0]),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // The datapath holds the link memory, head, prefetched link, count and result.
    fpfl_dp #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W),
        .CNT_W  (CNT_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_release_slot (i_s_axis_tdata[SLOT_W:1]),
        .o_sts          (sts),
        .o_status       (out_status),
        .o_granted_slot (out_granted),
        .o_free_count   (out_free)
    );

    generate
        if (OUT_PAD > 0) begin : g_pad
            assign o_m_axis_tdata = {{OUT_PAD{1'b0}}, out_free, out_granted, out_status};
        end else begin : g_nopad
            assign o_m_axis_tdata = {out_free, out_granted, out_status};
        end
    endgenerate

    // A result never reports more free slots than the pool holds.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_free <= CNT_W'(SLOTS)))
        else $error("free count above pool size");

    // An exhausted result grants nothing and reports an empty pool.
    a_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_status == STS_EXHAUSTED) |->
            (out_granted == '0 && out_free == '0))
        else $error("exhausted result inconsistent");

    // A request is only taken when the result register can receive its result.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register overrun");

    // Every accepted request presents a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("missing result");

endmodule
